>>> sv/qat_pkg.sv
package qat_pkg;

	localparam logic [7:0] BACKSLASH = 8'h5C;
	localparam logic [2:0] NO_QUOTE = 3'd7;
	// largest number of set bytes that the logic compares against
	localparam int unsigned SET_SIZE = 4;

	localparam logic [1:0] CFG_DELIMITER_CHARS = 2'd0;
	localparam logic [1:0] CFG_DELIMITER_COUNT = 2'd1;
	localparam logic [1:0] CFG_QUOTE_CHARS = 2'd2;
	localparam logic [1:0] CFG_QUOTE_COUNT = 2'd3;

	localparam logic [31:0] DELIMITER_CHARS_RST = 32'h0000_0020;
	localparam logic [2:0] DELIMITER_COUNT_RST = 3'd1;
	localparam logic [31:0] QUOTE_CHARS_RST = 32'h0000_0022;
	localparam logic [2:0] QUOTE_COUNT_RST = 3'd1;

	typedef struct packed {
		logic [7:0] in_char;
		logic end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic token_last;
		logic token_empty;
		logic token_overflow;
	} out_item_t;

	typedef struct packed {
		logic [31:0] delimiter_chars;
		logic [2:0] delimiter_count;
		logic [31:0] quote_chars;
		logic [2:0] quote_count;
	} cfg_t;

	// what the back end needs to know about a finished token
	typedef struct packed {
		logic quoted;
		logic [1:0] quote_idx;
		logic overflow;
	} tok_desc_t;

	function automatic logic [7:0] byte_at(input logic [31:0] word, input logic [1:0] idx);
		return word[{idx, 3'b000} +: 8];
	endfunction

	function automatic logic [2:0] set_used(input logic [2:0] count);
		logic [2:0] n;
		n = count;
		if (n > 3'd4) n = 3'd4;
		if (32'(n) > SET_SIZE) n = 3'(SET_SIZE);
		return n;
	endfunction

	function automatic logic set_match(input logic [31:0] word, input logic [2:0] count,
			input logic [7:0] c);
		logic hit;
		logic [2:0] n;
		hit = 1'b0;
		n = set_used(count);
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < n && byte_at(word, 2'(i)) == c) hit = 1'b1;
		end
		return hit;
	endfunction

	// index of the first matching quote byte, NO_QUOTE when none
	function automatic logic [2:0] quote_find(input logic [31:0] word, input logic [2:0] count,
			input logic [7:0] c);
		logic [2:0] idx;
		logic [2:0] n;
		idx = NO_QUOTE;
		n = set_used(count);
		for (int i = 3; i >= 0; i--) begin
			if (3'(i) < n && byte_at(word, 2'(i)) == c) idx = 3'(i);
		end
		return idx;
	endfunction

endpackage

>>> sv/quote_aware_tokenizer.sv
// Quote-aware tokenizer. Characters enter one per transfer on push/full; a
// configured delimiter or end_of_string closes a token, which is then unescaped
// and delivered one character per result transfer on empty/pop (token_last on
// the final one, token_empty alone for an empty quoted token, token_overflow on
// every item of a token longer than TOKEN_MAX). The front end takes one character
// per cycle into one of two token buffers; the back end replays a finished token
// from the buffer RAM with a read step and a decode step per stored character,
// plus an escape step for each backslash kept before a non-escapable character and
// per token an idle turnaround, a final length check and a closing step. The front
// end only stalls when both buffers hold tokens that the back end has not
// finished, so the sustained rate is set by the back end's read-decode loop. No
// clearing pass follows reset. cfg_ready is always high; write registers only
// while idle.
module quote_aware_tokenizer #(
	parameter int TOKEN_MAX = 32
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic push,
	output logic full,
	input qat_pkg::in_item_t in_data,
	output logic empty,
	input logic pop,
	output qat_pkg::out_item_t out_data
);

	localparam int IDX_W = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1;
	localparam int LEN_W = $clog2(TOKEN_MAX + 1);
	localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

	qat_pkg::cfg_t cfg_q;

	logic q_push;
	qat_pkg::tok_desc_t q_wr_desc;
	logic [LEN_W-1:0] q_wr_len;
	logic q_full;
	logic q_wr_bank;
	logic q_pop;
	logic q_valid;
	qat_pkg::tok_desc_t q_rd_desc;
	logic [LEN_W-1:0] q_rd_len;
	logic q_rd_bank;

	logic ram_we;
	logic [IDX_W:0] ram_waddr;
	logic [7:0] ram_wdata;
	logic ram_re;
	logic [IDX_W:0] ram_raddr;
	logic [7:0] ram_rdata;

	assign cfg_ready = 1'b1;
	assign full = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter_chars <= qat_pkg::DELIMITER_CHARS_RST;
			cfg_q.delimiter_count <= qat_pkg::DELIMITER_COUNT_RST;
			cfg_q.quote_chars <= qat_pkg::QUOTE_CHARS_RST;
			cfg_q.quote_count <= qat_pkg::QUOTE_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				qat_pkg::CFG_DELIMITER_CHARS: cfg_q.delimiter_chars <= cfg_data;
				qat_pkg::CFG_DELIMITER_COUNT: cfg_q.delimiter_count <= cfg_data[2:0];
				qat_pkg::CFG_QUOTE_CHARS: cfg_q.quote_chars <= cfg_data;
				qat_pkg::CFG_QUOTE_COUNT: cfg_q.quote_count <= cfg_data[2:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	qat_front #(
		.TOKEN_MAX(TOKEN_MAX),
		.IDX_W(IDX_W),
		.LEN_W(LEN_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.push(push),
		.in_data(in_data),
		.q_full(q_full),
		.q_bank(q_wr_bank),
		.q_push(q_push),
		.q_desc(q_wr_desc),
		.q_len(q_wr_len),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata)
	);

	qat_tok_queue #(
		.LEN_W(LEN_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wr_desc(q_wr_desc),
		.wr_len(q_wr_len),
		.full(q_full),
		.wr_bank(q_wr_bank),
		.pop(q_pop),
		.valid(q_valid),
		.rd_desc(q_rd_desc),
		.rd_len(q_rd_len),
		.rd_bank(q_rd_bank)
	);

	qat_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_buf (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	qat_back #(
		.IDX_W(IDX_W),
		.LEN_W(LEN_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_desc(q_rd_desc),
		.q_len(q_rd_len),
		.q_bank(q_rd_bank),
		.q_pop(q_pop),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.empty(empty),
		.pop(pop),
		.out_data(out_data)
	);

endmodule

>>> sv/qat_ram.sv
module qat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

>>> sv/qat_tok_queue.sv
module qat_tok_queue #(
	parameter int LEN_W = 6
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input qat_pkg::tok_desc_t wr_desc,
	input logic [LEN_W-1:0] wr_len,
	output logic full,
	output logic wr_bank,
	input logic pop,
	output logic valid,
	output qat_pkg::tok_desc_t rd_desc,
	output logic [LEN_W-1:0] rd_len,
	output logic rd_bank
);

	// one entry per buffer bank, so the pointers double as bank selects
	qat_pkg::tok_desc_t desc_q [2];
	logic [LEN_W-1:0] len_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				desc_q[wr_ptr_q] <= wr_desc;
				len_q[wr_ptr_q] <= wr_len;
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign full = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign wr_bank = wr_ptr_q;
	assign rd_bank = rd_ptr_q;
	assign rd_desc = desc_q[rd_ptr_q];
	assign rd_len = len_q[rd_ptr_q];

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && cnt_q == 2'd2))
		else $error("token queue written while full");
`endif

endmodule

>>> sv/qat_front.sv
module qat_front #(
	parameter int TOKEN_MAX = 32,
	parameter int IDX_W = 5,
	parameter int LEN_W = 6
) (
	input logic clk,
	input logic arst_n,
	input qat_pkg::cfg_t cfg,
	input logic push,
	input qat_pkg::in_item_t in_data,
	input logic q_full,
	input logic q_bank,
	output logic q_push,
	output qat_pkg::tok_desc_t q_desc,
	output logic [LEN_W-1:0] q_len,
	output logic ram_we,
	output logic [IDX_W:0] ram_waddr,
	output logic [7:0] ram_wdata
);

	logic [LEN_W-1:0] len_q;
	logic inside_q;
	logic [2:0] oqi_q;
	logic parity_q;
	logic ovf_q;
	logic first_bs_q;

	logic accept;
	logic [7:0] c;
	logic eos;
	logic keep;
	logic check_delim;
	logic n_inside;
	logic [2:0] n_oqi;
	logic n_parity;
	logic [2:0] qf;
	logic [7:0] open_byte;
	logic delim_hit;
	logic quoted;
	logic nothing;
	logic do_finish;
	logic room;

	always_comb begin
		accept = push && !q_full;
		c = in_data.in_char;
		eos = in_data.end_of_string;
		open_byte = qat_pkg::byte_at(cfg.quote_chars, oqi_q[1:0]);
		qf = qat_pkg::quote_find(cfg.quote_chars, cfg.quote_count, c);
		keep = 1'b1;
		check_delim = 1'b1;
		n_inside = inside_q;
		n_oqi = oqi_q;
		n_parity = parity_q;
		if (c == qat_pkg::BACKSLASH) begin
			n_parity = ~parity_q;
		end else if (inside_q) begin
			check_delim = 1'b0;
			if (c == open_byte && !parity_q) begin
				keep = 1'b0;
				n_inside = 1'b0;
			end
			n_parity = 1'b0;
		end else if (qf != qat_pkg::NO_QUOTE) begin
			if (!parity_q) begin
				n_inside = 1'b1;
				n_oqi = qf;
				keep = 1'b0;
				check_delim = 1'b0;
			end else begin
				n_parity = 1'b0;
			end
		end
		delim_hit = check_delim
			&& qat_pkg::set_match(cfg.delimiter_chars, cfg.delimiter_count, c);
		quoted = (oqi_q != qat_pkg::NO_QUOTE);
		// the token unescapes to nothing: empty, or a lone backslash
		nothing = (len_q == '0) || (len_q == LEN_W'(1) && first_bs_q);
		do_finish = eos ? (len_q != '0 || quoted) : delim_hit;
		q_push = accept && do_finish && !(nothing && !quoted);
		room = (len_q < LEN_W'(TOKEN_MAX));
		ram_we = accept && !eos && !delim_hit && keep && room;
	end

	assign q_desc = '{quoted: quoted, quote_idx: oqi_q[1:0], overflow: ovf_q};
	assign q_len = len_q;
	assign ram_waddr = {q_bank, len_q[IDX_W-1:0]};
	assign ram_wdata = c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			inside_q <= 1'b0;
			oqi_q <= qat_pkg::NO_QUOTE;
			parity_q <= 1'b0;
			ovf_q <= 1'b0;
			first_bs_q <= 1'b0;
		end else if (accept) begin
			if (eos || delim_hit) begin
				len_q <= '0;
				inside_q <= 1'b0;
				oqi_q <= qat_pkg::NO_QUOTE;
				ovf_q <= 1'b0;
				// a skipped token carries its escape parity forward
				parity_q <= (eos || q_push) ? 1'b0 : n_parity;
			end else begin
				inside_q <= n_inside;
				oqi_q <= n_oqi;
				parity_q <= n_parity;
				if (keep) begin
					if (room) begin
						len_q <= len_q + LEN_W'(1);
						if (len_q == '0) first_bs_q <= (c == qat_pkg::BACKSLASH);
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(TOKEN_MAX))
		else $error("token length beyond buffer");
	a_inside_has_quote: assert property (@(posedge clk) disable iff (!arst_n)
		inside_q |-> oqi_q != qat_pkg::NO_QUOTE)
		else $error("inside a block with no open quote");
`endif

endmodule

>>> sv/qat_back.sv
module qat_back #(
	parameter int IDX_W = 5,
	parameter int LEN_W = 6
) (
	input logic clk,
	input logic arst_n,
	input qat_pkg::cfg_t cfg,
	input logic q_valid,
	input qat_pkg::tok_desc_t q_desc,
	input logic [LEN_W-1:0] q_len,
	input logic q_bank,
	output logic q_pop,
	output logic ram_re,
	output logic [IDX_W:0] ram_raddr,
	input logic [7:0] ram_rdata,
	output logic empty,
	input logic pop,
	output qat_pkg::out_item_t out_data
);

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_PROC,
		B_ESC,
		B_LAST
	} state_t;

	state_t state_q;
	logic [LEN_W-1:0] idx_q;
	logic pending_q;
	logic [7:0] held_q;
	logic held_v_q;

	qat_pkg::out_item_t ofifo_q [2];
	logic ofifo_wptr_q;
	logic ofifo_rptr_q;
	logic [1:0] ofifo_cnt_q;

	logic [7:0] c;
	logic escapable;
	logic emit_req;
	logic [7:0] emit_char;
	logic ospace;
	logic can_emit;
	logic stall;
	logic last_push;
	logic opush;
	qat_pkg::out_item_t opush_item;

	always_comb begin
		c = ram_rdata;
		escapable = q_desc.quoted
			? (c == qat_pkg::byte_at(cfg.quote_chars, q_desc.quote_idx))
			: qat_pkg::set_match(cfg.quote_chars, cfg.quote_count, c);
		emit_req = 1'b0;
		emit_char = c;
		case (state_q)
			B_PROC: begin
				if (c == qat_pkg::BACKSLASH) begin
					emit_req = pending_q;
				end else if (pending_q) begin
					emit_req = 1'b1;
					if (!escapable) emit_char = qat_pkg::BACKSLASH;
				end else begin
					emit_req = 1'b1;
				end
			end
			B_ESC: emit_req = 1'b1;
			default: emit_req = 1'b0;
		endcase
		ospace = (ofifo_cnt_q != 2'd2);
		// the held char goes out once the next one shows it was not the last
		can_emit = !held_v_q || ospace;
		stall = emit_req && !can_emit;
		last_push = held_v_q || q_desc.quoted;
		opush = 1'b0;
		opush_item = '{out_char: held_q, token_last: 1'b0, token_empty: 1'b0,
			token_overflow: q_desc.overflow};
		if (emit_req && can_emit && held_v_q) begin
			opush = 1'b1;
		end else if (state_q == B_LAST && last_push && ospace) begin
			opush = 1'b1;
			opush_item.token_last = 1'b1;
			if (!held_v_q) begin
				opush_item.out_char = '0;
				opush_item.token_empty = 1'b1;
			end
		end
		q_pop = (state_q == B_LAST) && (!last_push || ospace);
		ram_re = (state_q == B_READ) && (idx_q < q_len);
		ram_raddr = {q_bank, idx_q[IDX_W-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q <= '0;
			pending_q <= 1'b0;
			held_q <= '0;
			held_v_q <= 1'b0;
		end else begin
			if (emit_req && can_emit) begin
				held_q <= emit_char;
				held_v_q <= 1'b1;
			end
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						state_q <= B_READ;
						idx_q <= '0;
						pending_q <= 1'b0;
						held_v_q <= 1'b0;
					end
				end
				B_READ: begin
					if (ram_re) begin
						idx_q <= idx_q + LEN_W'(1);
						state_q <= B_PROC;
					end else begin
						state_q <= B_LAST;
					end
				end
				B_PROC: begin
					if (!stall) begin
						if (c == qat_pkg::BACKSLASH) begin
							pending_q <= ~pending_q;
							state_q <= B_READ;
						end else if (pending_q && !escapable) begin
							// kept backslash first, then the char itself
							pending_q <= 1'b0;
							state_q <= B_ESC;
						end else begin
							pending_q <= 1'b0;
							state_q <= B_READ;
						end
					end
				end
				B_ESC: begin
					if (!stall) state_q <= B_READ;
				end
				B_LAST: begin
					if (q_pop) begin
						held_v_q <= 1'b0;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofifo_wptr_q <= 1'b0;
			ofifo_rptr_q <= 1'b0;
			ofifo_cnt_q <= 2'd0;
		end else begin
			if (opush) begin
				ofifo_q[ofifo_wptr_q] <= opush_item;
				ofifo_wptr_q <= ~ofifo_wptr_q;
			end
			if (pop && !empty) ofifo_rptr_q <= ~ofifo_rptr_q;
			ofifo_cnt_q <= ofifo_cnt_q + 2'(opush) - 2'(pop && !empty);
		end
	end

	assign empty = (ofifo_cnt_q == 2'd0);
	assign out_data = ofifo_q[ofifo_rptr_q];

`ifndef SYNTHESIS
	a_ofifo_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(opush && ofifo_cnt_q == 2'd2))
		else $error("result transfer into a full output queue");
	a_idle_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_IDLE |-> !held_v_q)
		else $error("held char left over after token end");
	a_work_has_token: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != B_IDLE |-> q_valid)
		else $error("token processing with no queued token");
`endif

endmodule
